>>> rtl/core/positional_insert_delete_list_core_defines.svh
// positional_insert_delete_list_core_defines.svh
// assertion macros shared by the list core rtl; no dependencies

`ifndef POSITIONAL_INSERT_DELETE_LIST_CORE_DEFINES_SVH
`define POSITIONAL_INSERT_DELETE_LIST_CORE_DEFINES_SVH

// same-cycle implication, checked at every rising edge outside reset
`define PIDL_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked at every rising edge outside reset
`define PIDL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/pidl_pkg.sv
// pidl_pkg.sv
// types and codes for the positional insert/delete list core; no dependencies

package pidl_pkg;

   // field types of the command and response items
   typedef logic                func_type;
   typedef logic        [1:0]   place_code_type;
   typedef logic        [5:0]   position_type;
   typedef logic signed [31:0]  value_type;
   typedef logic        [5:0]   count_type;

   // operation codes
   localparam func_type FUNC_INSERT = 1'b0;
   localparam func_type FUNC_DELETE = 1'b1;

   // where the command acts
   typedef enum logic [1:0] {
      PLACE_FRONT = 2'd0,
      PLACE_BACK  = 2'd1,
      PLACE_AT    = 2'd2
   } place_type;

   // response status
   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_BADPOS = 2'd3
   } status_type;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic shift_up;    // insert: open a gap at the index
      logic shift_down;  // delete: close the gap at the index
   } cell_ctl_type;

endpackage

>>> rtl/core/pidl_if.sv
// pidl_if.sv
// valid/ready channel interfaces for command and response items
// depends on pidl_pkg

interface pidl_req_if;
   import pidl_pkg::*;

   logic           valid;
   logic           ready;
   func_type       func;
   place_code_type place;
   position_type   position;
   value_type      value;

   modport source (output valid, func, place, position, value, input ready);
   modport sink   (input valid, func, place, position, value, output ready);
endinterface

interface pidl_rsp_if;
   import pidl_pkg::*;

   logic       valid;
   logic       ready;
   status_type status;
   value_type  removed_value;
   count_type  count;

   modport source (output valid, status, removed_value, count, input ready);
   modport sink   (input valid, status, removed_value, count, output ready);
endinterface

>>> rtl/core/pidl_cell.sv
// pidl_cell.sv
// one list slot: holds an entry and shifts it to or from its neighbors
// depends on pidl_pkg

module pidl_cell #(
   parameter int DEPTH = 32,
   parameter int INDEX = 0
) (
   input  logic                        clock,
   input  pidl_pkg::cell_ctl_type      ctl,
   input  logic [$clog2(DEPTH)-1:0]    idx,
   input  pidl_pkg::value_type         ins_value,
   input  pidl_pkg::value_type         left_i,
   input  pidl_pkg::value_type         right_i,
   output pidl_pkg::value_type         data_o,
   output pidl_pkg::value_type         tap_o
);
   import pidl_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   value_type data_ff;
   value_type data_in;
   logic      above;
   logic      at;

   // position of this slot relative to the command index
   assign above = (MY_IDX > idx);
   assign at    = (MY_IDX == idx);

   // shift, hold or load
   always_comb begin
      data_in = data_ff;
      if (ctl.shift_up) begin
         if (above) begin
            data_in = left_i;
         end else if (at) begin
            data_in = ins_value;
         end
      end else if (ctl.shift_down) begin
         if (above || at) begin
            data_in = right_i;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   // entry content and its share of the removed-value gather
   assign data_o = data_ff;
   assign tap_o  = at ? data_ff : '0;

endmodule

>>> rtl/core/positional_insert_delete_list_core.sv
// positional_insert_delete_list_core.sv
// top level: command decode, fill count, row of list cells, response register
// depends on pidl_pkg, pidl_if, pidl_cell and the defines header
//
// usage
//   req_ch carries one command item: func (insert/delete), place (front,
//   back or 1-based position) and value. rsp_ch returns exactly one item per
//   command: status, removed_value (nonzero only for a successful delete)
//   and the count after the command.
//   the response is registered and is valid in the cycle after the command is accepted.
//   throughput: one command per cycle while each response is taken; every cell decides
//   in the same cycle whether to shift, hold or load, so the whole row updates at once.
//   a stalled response holds in its register; req_ch.ready stays high while
//   the response register is empty or being taken in the same cycle, so a new
//   command enters as the previous response leaves.
//   reset clears the fill count and the response valid; entry contents are
//   not cleared and are never read before they are written.
//   refused commands (bad place code, full, empty, bad position) leave the
//   list unchanged.

`include "positional_insert_delete_list_core_defines.svh"

module positional_insert_delete_list_core #(
   parameter int DEPTH = 32
) (
   input  logic      clock,
   input  logic      reset,
   pidl_req_if.sink  req_ch,
   pidl_rsp_if.source rsp_ch
);
   import pidl_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = ((CNT_W > 6) ? CNT_W : 6) + 1;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

   logic [CNT_W-1:0] fill_count_ff;
   logic [CNT_W-1:0] fill_count_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   status_type       rsp_status_ff;
   value_type        rsp_removed_ff;
   count_type        rsp_count_ff;

   logic             accept;
   status_type       status;
   logic [IDX_W-1:0] idx;
   logic [CMP_W-1:0] pos_ext;
   logic [CMP_W-1:0] cnt_ext;
   logic             do_insert;
   logic             do_delete;
   cell_ctl_type     ctl;
   value_type        gathered;
   value_type        removed;

   value_type        cell_data [DEPTH];
   value_type        cell_tap  [DEPTH];

   // handshake: output register frees as it is taken
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   assign pos_ext = CMP_W'(req_ch.position);
   assign cnt_ext = CMP_W'(fill_count_ff);

   // command decode: status and target index
   always_comb begin
      status    = ST_OK;
      idx       = '0;
      do_insert = 1'b0;
      do_delete = 1'b0;
      unique case (req_ch.place)
         PLACE_FRONT: idx = '0;
         PLACE_BACK: begin
            if (req_ch.func == FUNC_INSERT) begin
               idx = IDX_W'(fill_count_ff);
            end else begin
               idx = IDX_W'(fill_count_ff - CNT_W'(1));
            end
         end
         PLACE_AT: idx = IDX_W'(req_ch.position - 6'd1);
         default:  status = ST_BADPOS;
      endcase
      if (status == ST_OK) begin
         if (req_ch.func == FUNC_INSERT) begin
            if (fill_count_ff >= CNT_MAX) begin
               status = ST_FULL;
            end else if (req_ch.place == PLACE_AT &&
                         (pos_ext == '0 || pos_ext > cnt_ext + CMP_W'(1))) begin
               status = ST_BADPOS;
            end else begin
               do_insert = 1'b1;
            end
         end else begin
            if (fill_count_ff == '0) begin
               status = ST_EMPTY;
            end else if (req_ch.place == PLACE_AT &&
                         (pos_ext == '0 || pos_ext > cnt_ext)) begin
               status = ST_BADPOS;
            end else begin
               do_delete = 1'b1;
            end
         end
      end
   end

   // broadcast to the row only for accepted, valid commands
   assign ctl.shift_up   = accept && do_insert;
   assign ctl.shift_down = accept && do_delete;

   // row of cells, each linked to its neighbors
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      value_type left_v;
      value_type right_v;
      if (i == 0) begin : g_first
         assign left_v = '0;
      end else begin : g_left
         assign left_v = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_v = cell_data[i];
      end else begin : g_right
         assign right_v = cell_data[i+1];
      end
      pidl_cell #(
         .DEPTH (DEPTH),
         .INDEX (i)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .idx       (idx),
         .ins_value (req_ch.value),
         .left_i    (left_v),
         .right_i   (right_v),
         .data_o    (cell_data[i]),
         .tap_o     (cell_tap[i])
      );
   end

   // gather the entry at the command index; at most one tap is nonzero
   always_comb begin
      gathered = '0;
      for (int i = 0; i < DEPTH; i++) begin
         gathered = gathered | cell_tap[i];
      end
   end

   assign removed = do_delete ? gathered : '0;

   // fill count update
   always_comb begin
      fill_count_in = fill_count_ff;
      if (ctl.shift_up) begin
         fill_count_in = fill_count_ff + CNT_W'(1);
      end else if (ctl.shift_down) begin
         fill_count_in = fill_count_ff - CNT_W'(1);
      end
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ch.ready);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         fill_count_ff <= fill_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // response payload register
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff  <= status;
         rsp_removed_ff <= removed;
         rsp_count_ff   <= 6'(fill_count_in);
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = rsp_status_ff;
   assign rsp_ch.removed_value = rsp_removed_ff;
   assign rsp_ch.count         = rsp_count_ff;

   // checks
   `PIDL_ASSERT_IMPL(a_count_range, clock, reset, 1'b1, fill_count_ff <= CNT_MAX,
      "fill count above depth")
   `PIDL_ASSERT_NEXT(a_rsp_follows, clock, reset, accept, rsp_valid_ff,
      "no response after accepted item")
   `PIDL_ASSERT_NEXT(a_refused_holds, clock, reset, accept && status != ST_OK,
      $stable(fill_count_ff), "refused item changed fill count")
   `PIDL_ASSERT_NEXT(a_insert_count, clock, reset, ctl.shift_up,
      fill_count_ff == $past(fill_count_ff) + CNT_W'(1), "insert did not grow count")
   `PIDL_ASSERT_IMPL(a_removed_zero, clock, reset, rsp_valid_ff && rsp_status_ff != ST_OK,
      rsp_removed_ff == '0, "refused item reports a removed value")

endmodule
